### src/kpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types, widths and codes of the key press classifier.
// ----------------------------------------------------------------------------
package kpc_pkg;

  // Sizing
  localparam int NUM_KEYS    = 4;
  localparam int COUNT_WIDTH = 16;
  localparam int TICK_W      = 16;
  localparam int CMP_W       = (COUNT_WIDTH > TICK_W) ? COUNT_WIDTH : TICK_W;
  localparam int CODE_W      = 3;
  localparam int IDX_W       = 3;
  localparam int CFG_W       = 16;
  localparam int PAYLOAD_W   = NUM_KEYS * 2 * CODE_W;
  localparam int IN_TDATA_W  = ((NUM_KEYS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PAYLOAD_W + 7) / 8) * 8;

  typedef logic [CODE_W-1:0]      code_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [TICK_W-1:0]      tick_t;
  typedef logic [IDX_W-1:0]       reg_idx_t;

  // Reported state codes
  localparam code_t ST_RELEASED = 3'd0;
  localparam code_t ST_DEBOUNCE = 3'd1;
  localparam code_t ST_PRESSED  = 3'd2;
  localparam code_t ST_LONG     = 3'd3;
  localparam code_t ST_XLONG    = 3'd4;
  localparam code_t ST_DISABLED = 3'd5;

  // Event codes
  localparam code_t EV_NONE     = 3'd0;
  localparam code_t EV_PRESSED  = 3'd1;
  localparam code_t EV_LONG     = 3'd2;
  localparam code_t EV_XLONG    = 3'd3;
  localparam code_t EV_RELEASED = 3'd4;

  // Configuration register indexes
  localparam reg_idx_t REG_ACTIVE_LEVELS = 3'd0;
  localparam reg_idx_t REG_DEBOUNCE      = 3'd1;
  localparam reg_idx_t REG_LONG          = 3'd2;
  localparam reg_idx_t REG_XLONG         = 3'd3;
  localparam reg_idx_t REG_DISABLE_MASK  = 3'd4;

  // Per-key state machine, one-hot
  typedef enum logic [5:0] {
    KS_RELEASED = 6'b000001,
    KS_DEBOUNCE = 6'b000010,
    KS_PRESSED  = 6'b000100,
    KS_LONG     = 6'b001000,
    KS_XLONG    = 6'b010000,
    KS_DISABLED = 6'b100000
  } key_state_t;

  // Thresholds shared by all lanes
  typedef struct packed {
    tick_t debounce;
    tick_t long_hold;
    tick_t xlong_hold;
  } kpc_thresh_t;

  // What one lane reports for one tick
  typedef struct packed {
    code_t ev;
    code_t st;
  } kpc_result_t;

  typedef kpc_result_t [NUM_KEYS-1:0] kpc_result_vec_t;

  // Map the one-hot state onto its reported code
  function automatic code_t state_code(key_state_t s);
    code_t c;
    c = ST_RELEASED;
    unique case (s)
      KS_RELEASED: c = ST_RELEASED;
      KS_DEBOUNCE: c = ST_DEBOUNCE;
      KS_PRESSED:  c = ST_PRESSED;
      KS_LONG:     c = ST_LONG;
      KS_XLONG:    c = ST_XLONG;
      KS_DISABLED: c = ST_DISABLED;
      default:     c = ST_RELEASED;
    endcase
    return c;
  endfunction

endpackage

### src/kpc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_lane
// One key: debounce and hold-time state machine with a saturating counter.
// ----------------------------------------------------------------------------
module kpc_lane (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  active,
  input  logic                  disabled,
  input  kpc_pkg::kpc_thresh_t  thresh,
  output kpc_pkg::kpc_result_t  result
);
  import kpc_pkg::*;

  key_state_t key_state, key_state_next, base_state;
  count_t     hold_count, hold_count_next, base_count, inc_count;
  code_t      ev;
  logic       hit_debounce, hit_long, hit_xlong;

  // Leaving disabled restarts from released with a clear counter
  always_comb begin
    if (key_state == KS_DISABLED) begin
      base_state = KS_RELEASED;
      base_count = '0;
    end else begin
      base_state = key_state;
      base_count = hold_count;
    end
  end

  // Saturating increment and threshold compares
  assign inc_count    = (&base_count) ? base_count : base_count + 1'b1;
  assign hit_debounce = CMP_W'(inc_count) >= CMP_W'(thresh.debounce);
  assign hit_long     = CMP_W'(inc_count) >= CMP_W'(thresh.long_hold);
  assign hit_xlong    = CMP_W'(inc_count) >= CMP_W'(thresh.xlong_hold);

  // Next state, counter and event for this tick
  always_comb begin
    key_state_next  = base_state;
    hold_count_next = base_count;
    ev              = EV_NONE;
    if (disabled) begin
      key_state_next  = KS_DISABLED;
      hold_count_next = hold_count;
    end else if (base_state == KS_RELEASED) begin
      if (active) begin
        key_state_next = KS_DEBOUNCE;
      end else begin
        hold_count_next = '0;
      end
    end else if (!active) begin
      key_state_next  = KS_RELEASED;
      hold_count_next = '0;
      ev              = (base_state == KS_DEBOUNCE) ? EV_NONE : EV_RELEASED;
    end else begin
      unique case (base_state)
        KS_DEBOUNCE: begin
          hold_count_next = inc_count;
          if (hit_debounce) begin
            key_state_next = KS_PRESSED;
            ev             = EV_PRESSED;
          end
        end
        KS_PRESSED: begin
          hold_count_next = inc_count;
          if (hit_long) begin
            key_state_next = KS_LONG;
            ev             = EV_LONG;
          end else begin
            ev = EV_PRESSED;
          end
        end
        KS_LONG: begin
          hold_count_next = inc_count;
          if (hit_xlong) begin
            key_state_next = KS_XLONG;
            ev             = EV_XLONG;
          end else begin
            ev = EV_LONG;
          end
        end
        KS_XLONG: begin
          ev = EV_XLONG;
        end
        default: begin
          key_state_next  = KS_RELEASED;
          hold_count_next = '0;
        end
      endcase
    end
  end

  assign result.st = state_code(key_state_next);
  assign result.ev = ev;

  // Advance on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      key_state  <= KS_RELEASED;
      hold_count <= '0;
    end else if (advance) begin
      key_state  <= key_state_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

### src/kpc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_merge
// Packs the lane results into one beat and holds it in a two-entry skid buffer.
// ----------------------------------------------------------------------------
module kpc_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  kpc_pkg::kpc_result_vec_t          lanes,
  output logic                              ready,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // state_key0, event_key0, state_key1, event_key1, ... from bit 0 up
  output logic [kpc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import kpc_pkg::*;

  logic [PAYLOAD_W-1:0]   payload;
  logic [OUT_TDATA_W-1:0] beat, main_data, skid_data;
  logic                   main_valid, skid_valid, pop;

  // Pack state then event per key, key 0 lowest
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      payload[k*2*CODE_W +: CODE_W]          = lanes[k].st;
      payload[k*2*CODE_W + CODE_W +: CODE_W] = lanes[k].ev;
    end
  end

  assign beat     = OUT_TDATA_W'(payload);
  assign pop      = main_valid & m_tready;
  assign ready    = ~skid_valid;
  assign m_tvalid = main_valid;
  assign m_tdata  = main_data;

  // Control of the two entries
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end
  end

  // Data of the two entries
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        main_data <= skid_data;
      end else begin
        main_data <= beat;
      end
    end else if (push) begin
      if (main_valid) begin
        skid_data <= beat;
      end else begin
        main_data <= beat;
      end
    end
  end

endmodule

### src/key_press_classifier_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_press_classifier_core
// Per-key debounce and long-press classifier, one lane per key.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          content
//  s_*      in         tvalid / tready    one tick: pin level of every key
//  m_*      out        tvalid / tready    state and event of every key
//  cfg_*    in         cfg_we             register write, no read-back
//
//  A tick is accepted each cycle s_tready is high; its result is registered.
//  All key lanes evaluate in parallel in the accept cycle; the skid buffer
//  in the merge stage holds up to two results.
//  s_tready drops only while two results wait on a stalled m_tready.
//  rst is synchronous: keys go to released, counters to zero, registers
//  to their defaults.
// ----------------------------------------------------------------------------
module key_press_classifier_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // pin_levels
  input  logic [kpc_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // state_key0, event_key0, state_key1, event_key1, state_key2, event_key2,
  // state_key3, event_key3
  output logic [kpc_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_we,
  input  logic [kpc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [kpc_pkg::CFG_W-1:0]         cfg_data
);
  import kpc_pkg::*;

  logic [NUM_KEYS-1:0] active_levels, disable_mask, active;
  kpc_thresh_t         thresh;
  kpc_result_vec_t     lanes;
  logic                accept;

  assign accept = s_tvalid & s_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_levels     <= '1;
      thresh.debounce   <= TICK_W'(3);
      thresh.long_hold  <= TICK_W'(100);
      thresh.xlong_hold <= TICK_W'(300);
      disable_mask      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_LEVELS: active_levels     <= cfg_data[NUM_KEYS-1:0];
        REG_DEBOUNCE:      thresh.debounce   <= cfg_data[TICK_W-1:0];
        REG_LONG:          thresh.long_hold  <= cfg_data[TICK_W-1:0];
        REG_XLONG:         thresh.xlong_hold <= cfg_data[TICK_W-1:0];
        REG_DISABLE_MASK:  disable_mask      <= cfg_data[NUM_KEYS-1:0];
        default: ;
      endcase
    end
  end

  // A key is held when its pin matches its active level
  assign active = ~(s_tdata[NUM_KEYS-1:0] ^ active_levels);

  // One lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kpc_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .advance  (accept),
      .active   (active[k]),
      .disabled (disable_mask[k]),
      .thresh   (thresh),
      .result   (lanes[k])
    );
  end

  // Merge lane results into the output beat
  kpc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .lanes    (lanes),
    .ready    (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A full buffer always has a beat on offer
  a_stall_has_beat: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no output beat pending");

  // An accepted tick always yields a pending beat next cycle
  a_accept_yields_beat: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted tick produced no output beat");

  // A release event leaves the key released; a disabled key gives no event
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_chk
    a_event_state: assert property (@(posedge clk) disable iff (rst)
      ((lanes[k].ev == EV_RELEASED) |-> (lanes[k].st == ST_RELEASED)) and
      ((lanes[k].st == ST_DISABLED) |-> (lanes[k].ev == EV_NONE)))
      else $error("key event does not match its state");
  end

endmodule
